### hdl/cmt_pkg.sv
// shared types and codes for the counting multiset table
package cmt_pkg;

  // request codes
  localparam logic [2:0] REQ_INSERT    = 3'd0;
  localparam logic [2:0] REQ_ERASE_ONE = 3'd1;
  localparam logic [2:0] REQ_ERASE_ALL = 3'd2;
  localparam logic [2:0] REQ_COUNT     = 3'd3;
  localparam logic [2:0] REQ_GET       = 3'd4;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_SATURATED = 2'd3;

  // cell update codes
  localparam int          CELL_OP_W   = 3;
  localparam logic [2:0] CELL_HOLD   = 3'd0;
  localparam logic [2:0] CELL_INC    = 3'd1;
  localparam logic [2:0] CELL_DEC    = 3'd2;
  localparam logic [2:0] CELL_APPEND = 3'd3;
  localparam logic [2:0] CELL_SHIFT  = 3'd4;

  // input beat
  typedef struct packed {
    logic [2:0]  req_type;
    logic [31:0] key;
    logic [5:0]  position;
  } req_t;

  // result beat
  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] result_count;
    logic [31:0] key_out;
    logic [6:0]  distinct_entries;
    logic [21:0] total_items;
  } rsp_t;

  // broadcast control to every cell
  typedef struct packed {
    logic                 load;
    logic                 req_get;
    logic                 exe;
    logic [CELL_OP_W-1:0] op;
  } cell_cmd_t;

endpackage

### hdl/cmt_cell.sv
// one table cell: key, count and a registered match flag
module cmt_cell #(
  parameter int IDX         = 0,
  parameter int KEY_WIDTH   = 32,
  parameter int COUNT_WIDTH = 16,
  parameter int IDX_W       = 6,
  parameter int USED_W      = 7
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cmt_pkg::cell_cmd_t     cmd,
  input  logic [KEY_WIDTH-1:0]   bus_key,
  input  logic [5:0]             bus_pos,
  input  logic [USED_W-1:0]      used,
  input  logic [IDX_W-1:0]       idx,
  input  logic [KEY_WIDTH-1:0]   nbr_key,
  input  logic [COUNT_WIDTH-1:0] nbr_cnt,
  output logic [KEY_WIDTH-1:0]   cell_key,
  output logic [COUNT_WIDTH-1:0] cell_cnt,
  output logic                   hit
);

  logic [KEY_WIDTH-1:0]   key_r, key_nxt;
  logic [COUNT_WIDTH-1:0] cnt_r, cnt_nxt;
  logic                   hit_r, hit_nxt;
  logic                   occupied;
  logic                   at_pos;

  assign occupied = (used > USED_W'(IDX));
  assign at_pos   = (32'(bus_pos) == 32'(IDX));

  // match flag captured when the request beat arrives
  always_comb begin
    hit_nxt = hit_r;
    if (cmd.load) begin
      hit_nxt = occupied && (cmd.req_get ? at_pos : (bus_key == key_r));
    end
  end

  // entry update on the execute cycle
  always_comb begin
    key_nxt = key_r;
    cnt_nxt = cnt_r;
    if (cmd.exe) begin
      case (cmd.op)
        cmt_pkg::CELL_INC: begin
          if (hit_r) cnt_nxt = cnt_r + COUNT_WIDTH'(1);
        end
        cmt_pkg::CELL_DEC: begin
          if (hit_r) cnt_nxt = cnt_r - COUNT_WIDTH'(1);
        end
        cmt_pkg::CELL_APPEND: begin
          if (used == USED_W'(IDX)) begin
            key_nxt = bus_key;
            cnt_nxt = COUNT_WIDTH'(1);
          end
        end
        cmt_pkg::CELL_SHIFT: begin
          if (idx <= IDX_W'(IDX)) begin
            key_nxt = nbr_key;
            cnt_nxt = nbr_cnt;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else begin
      hit_r <= hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    cnt_r <= cnt_nxt;
  end

  assign cell_key = key_r;
  assign cell_cnt = cnt_r;
  assign hit      = hit_r;

endmodule

### hdl/cmt_select.sv
// gathers the matching cell's position, key and count from the match flags
module cmt_select #(
  parameter int TABLE_DEPTH = 64,
  parameter int KEY_WIDTH   = 32,
  parameter int COUNT_WIDTH = 16,
  parameter int IDX_W       = 6
) (
  input  logic [TABLE_DEPTH-1:0] hit_vec,
  input  logic [KEY_WIDTH-1:0]   keys [TABLE_DEPTH],
  input  logic [COUNT_WIDTH-1:0] cnts [TABLE_DEPTH],
  output logic                   found,
  output logic [IDX_W-1:0]       idx,
  output logic [KEY_WIDTH-1:0]   sel_key,
  output logic [COUNT_WIDTH-1:0] sel_cnt
);

  // flags are one-hot among held entries, so an or-tree selects
  always_comb begin
    idx     = '0;
    sel_key = '0;
    sel_cnt = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (hit_vec[i]) begin
        idx     = idx | IDX_W'(i);
        sel_key = sel_key | keys[i];
        sel_cnt = sel_cnt | cnts[i];
      end
    end
  end

  assign found = |hit_vec;

endmodule

### hdl/counting_multiset_table.sv
// counting multiset table: top level with control, counters and the row of cells
//
// Keeps distinct keys in insertion order, each with an occurrence count, in a
// row of cells. A request beat arrives on in_valid/in_ready with in_data
// (insert, erase one, erase all, count query, get by position); one result
// beat leaves on out_valid/out_ready with out_data for every request.
// On the accept edge every cell compares the key (or its position for a get)
// and stores a match flag. In the execute state that follows, once the output
// register is free, the matching entry is gathered, the update is applied in
// all cells at once (increment, decrement, append, or a one-place shift toward
// the head that closes a gap) and the result is written to the output register.
// A new request is taken only after the previous one has executed.
// While a result waits in the output register, the next request is still
// accepted; its execute cycle waits until the held result is taken.
// Reset empties the table and clears both counters; no clearing pass is
// needed, entries beyond the fill count are never read.
module counting_multiset_table #(
  parameter int TABLE_DEPTH = 64,
  parameter int KEY_WIDTH   = 32,
  parameter int COUNT_WIDTH = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  cmt_pkg::req_t   in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output cmt_pkg::rsp_t   out_data
);

  localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int USED_W = $clog2(TABLE_DEPTH + 1);
  localparam int TOT_W  = COUNT_WIDTH + IDX_W + 1;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXE  = 1'b1;

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

  logic                   state_r, state_nxt;
  cmt_pkg::req_t          req_r;
  logic [USED_W-1:0]      used_r, used_nxt;
  logic [TOT_W-1:0]       total_r, total_nxt;
  logic                   out_valid_r, out_valid_nxt;
  cmt_pkg::rsp_t          out_data_r;

  logic                   in_fire;
  logic                   exe_go;
  cmt_pkg::cell_cmd_t     cmd;
  logic [2:0]             cell_op;
  logic [KEY_WIDTH-1:0]   in_key_ext, req_key_ext, bus_key;

  logic [TABLE_DEPTH-1:0] hit_vec;
  logic [KEY_WIDTH-1:0]   cell_keys [TABLE_DEPTH];
  logic [COUNT_WIDTH-1:0] cell_cnts [TABLE_DEPTH];

  logic                   found;
  logic [IDX_W-1:0]       sel_idx;
  logic [KEY_WIDTH-1:0]   sel_key;
  logic [COUNT_WIDTH-1:0] sel_cnt;

  logic [1:0]             status;
  logic [COUNT_WIDTH-1:0] rcount;
  logic [KEY_WIDTH-1:0]   kout;

  logic [15:0]            rcount_o;
  logic [31:0]            kout_o;
  logic [6:0]             used_o;
  logic [21:0]            total_o;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign exe_go   = (state_r == S_EXE) && (!out_valid_r || out_ready);

  // key fitted to the stored key width
  generate
    if (KEY_WIDTH <= 32) begin : g_key_narrow
      assign in_key_ext  = in_data.key[KEY_WIDTH-1:0];
      assign req_key_ext = req_r.key[KEY_WIDTH-1:0];
    end else begin : g_key_wide
      assign in_key_ext  = {{(KEY_WIDTH-32){1'b0}}, in_data.key};
      assign req_key_ext = {{(KEY_WIDTH-32){1'b0}}, req_r.key};
    end
  endgenerate

  assign bus_key = (state_r == S_IDLE) ? in_key_ext : req_key_ext;

  // row of cells, each but the last shifting from its upper neighbor
  generate
    for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      logic [KEY_WIDTH-1:0]   nbr_key;
      logic [COUNT_WIDTH-1:0] nbr_cnt;
      if (i == TABLE_DEPTH - 1) begin : g_last
        assign nbr_key = cell_keys[i];
        assign nbr_cnt = cell_cnts[i];
      end else begin : g_mid
        assign nbr_key = cell_keys[i+1];
        assign nbr_cnt = cell_cnts[i+1];
      end
      cmt_cell #(
        .IDX         (i),
        .KEY_WIDTH   (KEY_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH),
        .IDX_W       (IDX_W),
        .USED_W      (USED_W)
      ) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .bus_key  (bus_key),
        .bus_pos  (in_data.position),
        .used     (used_r),
        .idx      (sel_idx),
        .nbr_key  (nbr_key),
        .nbr_cnt  (nbr_cnt),
        .cell_key (cell_keys[i]),
        .cell_cnt (cell_cnts[i]),
        .hit      (hit_vec[i])
      );
    end
  endgenerate

  cmt_select #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_WIDTH   (KEY_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH),
    .IDX_W       (IDX_W)
  ) u_select (
    .hit_vec (hit_vec),
    .keys    (cell_keys),
    .cnts    (cell_cnts),
    .found   (found),
    .idx     (sel_idx),
    .sel_key (sel_key),
    .sel_cnt (sel_cnt)
  );

  // request decode on the execute cycle
  always_comb begin
    status    = cmt_pkg::ST_NOT_FOUND;
    rcount    = '0;
    kout      = '0;
    cell_op   = cmt_pkg::CELL_HOLD;
    used_nxt  = used_r;
    total_nxt = total_r;
    case (req_r.req_type)
      cmt_pkg::REQ_INSERT: begin
        if (found) begin
          if (sel_cnt == CNT_MAX) begin
            status = cmt_pkg::ST_SATURATED;
            rcount = CNT_MAX;
          end else begin
            status    = cmt_pkg::ST_OK;
            rcount    = sel_cnt + COUNT_WIDTH'(1);
            cell_op   = cmt_pkg::CELL_INC;
            total_nxt = total_r + TOT_W'(1);
          end
        end else if (used_r == USED_W'(TABLE_DEPTH)) begin
          status = cmt_pkg::ST_FULL;
        end else begin
          status    = cmt_pkg::ST_OK;
          rcount    = COUNT_WIDTH'(1);
          cell_op   = cmt_pkg::CELL_APPEND;
          used_nxt  = used_r + USED_W'(1);
          total_nxt = total_r + TOT_W'(1);
        end
      end
      cmt_pkg::REQ_ERASE_ONE: begin
        if (found) begin
          status = cmt_pkg::ST_OK;
          rcount = COUNT_WIDTH'(1);
          if (sel_cnt > COUNT_WIDTH'(1)) begin
            cell_op = cmt_pkg::CELL_DEC;
          end else begin
            cell_op  = cmt_pkg::CELL_SHIFT;
            used_nxt = used_r - USED_W'(1);
          end
          if (total_r != '0) total_nxt = total_r - TOT_W'(1);
        end
      end
      cmt_pkg::REQ_ERASE_ALL: begin
        if (found) begin
          status   = cmt_pkg::ST_OK;
          rcount   = sel_cnt;
          cell_op  = cmt_pkg::CELL_SHIFT;
          used_nxt = used_r - USED_W'(1);
          if (total_r >= {{(TOT_W-COUNT_WIDTH){1'b0}}, sel_cnt}) begin
            total_nxt = total_r - {{(TOT_W-COUNT_WIDTH){1'b0}}, sel_cnt};
          end else begin
            total_nxt = '0;
          end
        end
      end
      cmt_pkg::REQ_COUNT: begin
        if (found) begin
          status = cmt_pkg::ST_OK;
          rcount = sel_cnt;
        end
      end
      cmt_pkg::REQ_GET: begin
        if (found) begin
          status = cmt_pkg::ST_OK;
          rcount = sel_cnt;
          kout   = sel_key;
        end
      end
      default: begin
      end
    endcase
  end

  // cell control
  always_comb begin
    cmd.load    = in_fire;
    cmd.req_get = (in_data.req_type == cmt_pkg::REQ_GET);
    cmd.exe     = exe_go;
    cmd.op      = cell_op;
  end

  // fit result fields to the beat widths
  generate
    if (COUNT_WIDTH >= 16) begin : g_rc_wide
      assign rcount_o = rcount[15:0];
    end else begin : g_rc_narrow
      assign rcount_o = {{(16-COUNT_WIDTH){1'b0}}, rcount};
    end
    if (KEY_WIDTH >= 32) begin : g_ko_wide
      assign kout_o = kout[31:0];
    end else begin : g_ko_narrow
      assign kout_o = {{(32-KEY_WIDTH){1'b0}}, kout};
    end
    if (USED_W >= 7) begin : g_used_wide
      assign used_o = used_nxt[6:0];
    end else begin : g_used_narrow
      assign used_o = {{(7-USED_W){1'b0}}, used_nxt};
    end
    if (TOT_W >= 22) begin : g_tot_wide
      assign total_o = total_nxt[21:0];
    end else begin : g_tot_narrow
      assign total_o = {{(22-TOT_W){1'b0}}, total_nxt};
    end
  endgenerate

  // sequencing and output slot
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_fire) state_nxt = S_EXE;
      end
      S_EXE: begin
        if (exe_go) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      used_r      <= '0;
      total_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (exe_go) begin
        used_r  <= used_nxt;
        total_r <= total_nxt;
      end
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    if (in_fire) req_r <= in_data;
    if (exe_go) begin
      out_data_r.status           <= status;
      out_data_r.result_count     <= rcount_o;
      out_data_r.key_out          <= kout_o;
      out_data_r.distinct_entries <= used_o;
      out_data_r.total_items      <= total_o;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // held keys are distinct, so at most one cell matches
  a_hit_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXE) |-> $onehot0(hit_vec))
    else $error("more than one cell matched");

  // every held entry carries at least one item
  a_total_covers_used: assert property (@(posedge clk) disable iff (!rst_n)
    total_r >= TOT_W'(used_r))
    else $error("item total below entry count");

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= USED_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  // a request leads to exactly one result beat before the next is taken
  a_exe_fills_slot: assert property (@(posedge clk) disable iff (!rst_n)
    exe_go |=> (out_valid_r && (state_r == S_IDLE)))
    else $error("execute cycle did not post a result");

endmodule
